// ===== rtl/thp_pkg.sv =====
package thp_pkg;

  // Field widths of one report, one result and the configuration registers
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned DirW      = 4;
  localparam int unsigned ThreshW   = 17;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned DeadzoneW = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned InFieldsW  = TimeW + 4 + 4 * CoordW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 4 + 2 * DirW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // tan(40) and tan(50) in Q16, both odd so nonzero points never tie
  localparam logic [16:0] Tan40Q16 = 17'd54991;
  localparam logic [16:0] Tan50Q16 = 17'd78103;

  // D-pad direction bits
  localparam logic [DirW-1:0] DirNone  = 4'b0000;
  localparam logic [DirW-1:0] DirUp    = 4'b0001;
  localparam logic [DirW-1:0] DirRight = 4'b0010;
  localparam logic [DirW-1:0] DirDown  = 4'b0100;
  localparam logic [DirW-1:0] DirLeft  = 4'b1000;

  // Register reset values
  localparam logic [ThreshW-1:0]   MoveThresholdRst = 17'd1800;
  localparam logic [IntervalW-1:0] PulseIntervalRst = 16'd22;
  localparam logic [DeadzoneW-1:0] DpadDeadzoneRst  = 16'd9000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegMotionMode   = 3'd0,
    RegMouseEnable  = 3'd1,
    RegMouseOnLeft  = 3'd2,
    RegDpadEnable   = 3'd3,
    RegDpadOnRight  = 3'd4,
    RegMoveThresh   = 3'd5,
    RegPulseInterval = 3'd6,
    RegDpadDeadzone = 3'd7
  } thp_reg_e;

  // Role of one pad
  typedef struct packed {
    logic dpad;
    logic mouse;
    logic native;
  } thp_role_t;

  // Shared thresholds
  typedef struct packed {
    logic [ThreshW-1:0]   move_threshold;
    logic [IntervalW-1:0] pulse_interval;
    logic [DeadzoneW-1:0] dpad_deadzone;
  } thp_cfg_t;

  // Per-pad result
  typedef struct packed {
    logic            strong_pulse;
    logic            soft_pulse;
    logic [DirW-1:0] dir;
  } thp_pad_res_t;

  // Input report, first field in the lowest bits
  typedef struct packed {
    logic [InDataW-InFieldsW-1:0] fill;
    logic signed [CoordW-1:0]     right_y;
    logic signed [CoordW-1:0]     right_x;
    logic signed [CoordW-1:0]     left_y;
    logic signed [CoordW-1:0]     left_x;
    logic                         right_click;
    logic                         left_click;
    logic                         right_touch;
    logic                         left_touch;
    logic [TimeW-1:0]             time_ms;
  } thp_in_t;

  // Result item, first field in the lowest bits
  typedef struct packed {
    logic [OutDataW-OutFieldsW-1:0] fill;
    logic [DirW-1:0]                right_direction;
    logic [DirW-1:0]                left_direction;
    logic                           right_soft;
    logic                           left_soft;
    logic                           right_strong;
    logic                           left_strong;
  } thp_out_t;

endpackage

// ===== rtl/thp_dir.sv =====
module thp_dir (
  input  logic signed [thp_pkg::CoordW-1:0]    x_i,
  input  logic signed [thp_pkg::CoordW-1:0]    y_i,
  input  logic        [thp_pkg::DeadzoneW-1:0] deadzone_i,
  output logic        [thp_pkg::DirW-1:0]      dir_o
);
  import thp_pkg::*;

  logic signed [CoordW:0] xe, ye;
  logic [CoordW:0]        ax, ay;
  logic [32:0]            ys;
  logic [33:0]            xs40, xs50;
  logic [DirW-1:0]        hx, vy;
  logic                   in_dz;

  // Magnitudes, 17 bits so that -32768 fits
  assign xe = {x_i[CoordW-1], x_i};
  assign ye = {y_i[CoordW-1], y_i};
  assign ax = xe[CoordW] ? (CoordW+1)'(-xe) : (CoordW+1)'(xe);
  assign ay = ye[CoordW] ? (CoordW+1)'(-ye) : (CoordW+1)'(ye);

  assign in_dz = (ax < {1'b0, deadzone_i}) && (ay < {1'b0, deadzone_i});

  // Sector boundaries by tangent compare
  assign ys   = {ay, 16'b0};
  assign xs40 = 34'(ax) * 34'(Tan40Q16);
  assign xs50 = 34'(ax) * 34'(Tan50Q16);

  assign hx = x_i[CoordW-1] ? DirLeft : DirRight;
  assign vy = y_i[CoordW-1] ? DirDown : DirUp;

  always_comb begin
    if (in_dz) begin
      dir_o = DirNone;
    end else if (ax == '0 && ay == '0) begin
      dir_o = DirRight;
    end else if ({1'b0, ys} < xs40) begin
      dir_o = hx;
    end else if ({1'b0, ys} < xs50) begin
      dir_o = hx | vy;
    end else begin
      dir_o = vy;
    end
  end

endmodule

// ===== rtl/thp_pad.sv =====
module thp_pad (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              clear_i,
  input  thp_pkg::thp_role_t                role_i,
  input  thp_pkg::thp_cfg_t                 cfg_i,
  input  logic        [thp_pkg::TimeW-1:0]  now_i,
  input  logic                              touch_i,
  input  logic                              click_i,
  input  logic signed [thp_pkg::CoordW-1:0] x_i,
  input  logic signed [thp_pkg::CoordW-1:0] y_i,
  output thp_pkg::thp_pad_res_t             res_o
);
  import thp_pkg::*;

  // Pad history
  logic                     prev_click_q, prev_click_d;
  logic [DirW-1:0]          prev_dir_q, prev_dir_d;
  logic                     prev_touch_q, prev_touch_d;
  logic signed [CoordW-1:0] anchor_x_q, anchor_x_d;
  logic signed [CoordW-1:0] anchor_y_q, anchor_y_d;
  logic [TimeW-1:0]         last_pulse_q, last_pulse_d;
  logic                     pulsed_q, pulsed_d;

  logic                   eligible, takes_touch, now_click;
  logic                   cpulse, dpulse, strong_pulse, soft_pulse;
  logic                   moved, elapsed;
  logic [DirW-1:0]        mask, dir;
  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        adx, ady;
  logic [ThreshW-1:0]     travel;
  logic [TimeW-1:0]       since;

  thp_dir u_dir (
    .x_i        (x_i),
    .y_i        (y_i),
    .deadzone_i (cfg_i.dpad_deadzone),
    .dir_o      (mask)
  );

  // Click and d-pad pulses
  assign eligible     = role_i.mouse | role_i.native | role_i.dpad;
  assign takes_touch  = (role_i.mouse | role_i.native) & touch_i;
  assign now_click    = eligible & click_i;
  assign cpulse       = now_click != prev_click_q;
  assign dir          = (role_i.dpad && now_click) ? mask : DirNone;
  assign dpulse       = role_i.dpad & now_click & ~cpulse & (dir != prev_dir_q);
  assign strong_pulse = cpulse | dpulse;

  // Travel from anchor
  assign dx     = {x_i[CoordW-1], x_i} - {anchor_x_q[CoordW-1], anchor_x_q};
  assign dy     = {y_i[CoordW-1], y_i} - {anchor_y_q[CoordW-1], anchor_y_q};
  assign adx    = dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
  assign ady    = dy[CoordW] ? (CoordW+1)'(-dy) : (CoordW+1)'(dy);
  assign travel = ThreshW'(adx) + ThreshW'(ady);

  assign moved      = prev_touch_q && (travel >= cfg_i.move_threshold);
  assign since      = now_i - last_pulse_q;
  assign elapsed    = !pulsed_q || (since >= TimeW'(cfg_i.pulse_interval));
  assign soft_pulse = takes_touch & moved & ~strong_pulse & elapsed;

  // Next history
  always_comb begin
    prev_click_d = prev_click_q;
    prev_dir_d   = prev_dir_q;
    prev_touch_d = prev_touch_q;
    anchor_x_d   = anchor_x_q;
    anchor_y_d   = anchor_y_q;
    last_pulse_d = last_pulse_q;
    pulsed_d     = pulsed_q;
    if (clear_i) begin
      prev_click_d = 1'b0;
      prev_dir_d   = DirNone;
      prev_touch_d = 1'b0;
    end else if (step_i) begin
      prev_click_d = now_click;
      prev_dir_d   = dir;
      prev_touch_d = takes_touch;
      if (strong_pulse || soft_pulse) begin
        last_pulse_d = now_i;
        pulsed_d     = 1'b1;
      end
      if (soft_pulse || (takes_touch && !prev_touch_q)) begin
        anchor_x_d = x_i;
        anchor_y_d = y_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_click_q <= 1'b0;
      prev_dir_q   <= DirNone;
      prev_touch_q <= 1'b0;
      anchor_x_q   <= '0;
      anchor_y_q   <= '0;
      last_pulse_q <= '0;
      pulsed_q     <= 1'b0;
    end else begin
      prev_click_q <= prev_click_d;
      prev_dir_q   <= prev_dir_d;
      prev_touch_q <= prev_touch_d;
      anchor_x_q   <= anchor_x_d;
      anchor_y_q   <= anchor_y_d;
      last_pulse_q <= last_pulse_d;
      pulsed_q     <= pulsed_d;
    end
  end

  assign res_o.strong_pulse = strong_pulse;
  assign res_o.soft_pulse   = soft_pulse;
  assign res_o.dir          = dir;

endmodule

// ===== rtl/trackpad_haptic_pulse_generator.sv =====
// A report accepted into the input register passes through both pads into the result
// register, which drives the result port; a stalled result port holds it back.
// Throughput: one report per cycle while the result port is not stalled; the input
// register and the result register each take a new transaction when empty or drained.
// Reset (rst_ni low, asynchronous): pad history, anchors and pulse times go to
// zero, configuration returns to its defaults, both stages are emptied.
module trackpad_haptic_pulse_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input reports
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] time_ms, [32] left_touch, [33] right_touch, [34] left_click,
  // [35] right_click, [51:36] left_x, [67:52] left_y, [83:68] right_x,
  // [99:84] right_y, [103:100] zero
  input  logic [thp_pkg::InDataW-1:0]         s_axis_tdata,
  // Results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] left_strong, [1] right_strong, [2] left_soft, [3] right_soft,
  // [7:4] left_direction, [11:8] right_direction, [15:12] zero
  output logic [thp_pkg::OutDataW-1:0]        m_axis_tdata,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [thp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [thp_pkg::CfgDataW-1:0]        cfg_data_i
);
  import thp_pkg::*;

  // Configuration registers
  logic                 motion_mode_q, mouse_enable_q, mouse_on_left_q;
  logic                 dpad_enable_q, dpad_on_right_q;
  logic [ThreshW-1:0]   move_threshold_q;
  logic [IntervalW-1:0] pulse_interval_q;
  logic [DeadzoneW-1:0] dpad_deadzone_q;

  // Pipeline registers
  logic     in_vld_q, in_vld_d;
  thp_in_t  in_q;
  logic     out_vld_q, out_vld_d;
  thp_out_t out_q, out_d;

  logic         adv, step, load;
  logic         mouse_on;
  thp_role_t    role_l, role_r;
  thp_cfg_t     cfg;
  thp_pad_res_t res_l, res_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_mode_q    <= 1'b0;
      mouse_enable_q   <= 1'b0;
      mouse_on_left_q  <= 1'b0;
      dpad_enable_q    <= 1'b0;
      dpad_on_right_q  <= 1'b0;
      move_threshold_q <= MoveThresholdRst;
      pulse_interval_q <= PulseIntervalRst;
      dpad_deadzone_q  <= DpadDeadzoneRst;
    end else if (cfg_we_i) begin
      case (thp_reg_e'(cfg_idx_i))
        RegMotionMode:    motion_mode_q    <= cfg_data_i[0];
        RegMouseEnable:   mouse_enable_q   <= cfg_data_i[0];
        RegMouseOnLeft:   mouse_on_left_q  <= cfg_data_i[0];
        RegDpadEnable:    dpad_enable_q    <= cfg_data_i[0];
        RegDpadOnRight:   dpad_on_right_q  <= cfg_data_i[0];
        RegMoveThresh:    move_threshold_q <= cfg_data_i[ThreshW-1:0];
        RegPulseInterval: pulse_interval_q <= cfg_data_i[IntervalW-1:0];
        RegDpadDeadzone:  dpad_deadzone_q  <= cfg_data_i[DeadzoneW-1:0];
        default: ;
      endcase
    end
  end

  // Pad roles; d-pad in motion mode locks out the mouse
  assign mouse_on      = mouse_enable_q & ~(motion_mode_q & dpad_enable_q);
  assign role_l.dpad   = dpad_enable_q & ~dpad_on_right_q;
  assign role_r.dpad   = dpad_enable_q & dpad_on_right_q;
  assign role_l.mouse  = mouse_on & mouse_on_left_q;
  assign role_r.mouse  = mouse_on & ~mouse_on_left_q;
  assign role_l.native = motion_mode_q & ~role_l.mouse & ~role_l.dpad;
  assign role_r.native = motion_mode_q & ~role_r.mouse & ~role_r.dpad;

  assign cfg.move_threshold = move_threshold_q;
  assign cfg.pulse_interval = pulse_interval_q;
  assign cfg.dpad_deadzone  = dpad_deadzone_q;

  // Handshake: result stage frees when empty or drained
  assign adv           = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = load ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d     = adv ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= thp_in_t'(s_axis_tdata);
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  thp_pad u_pad_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (cfg_we_i),
    .role_i  (role_l),
    .cfg_i   (cfg),
    .now_i   (in_q.time_ms),
    .touch_i (in_q.left_touch),
    .click_i (in_q.left_click),
    .x_i     (in_q.left_x),
    .y_i     (in_q.left_y),
    .res_o   (res_l)
  );

  thp_pad u_pad_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (cfg_we_i),
    .role_i  (role_r),
    .cfg_i   (cfg),
    .now_i   (in_q.time_ms),
    .touch_i (in_q.right_touch),
    .click_i (in_q.right_click),
    .x_i     (in_q.right_x),
    .y_i     (in_q.right_y),
    .res_o   (res_r)
  );

  // Pack result transaction
  always_comb begin
    out_d                 = '0;
    out_d.left_strong     = res_l.strong_pulse;
    out_d.right_strong    = res_r.strong_pulse;
    out_d.left_soft       = res_l.soft_pulse;
    out_d.right_soft      = res_r.soft_pulse;
    out_d.left_direction  = res_l.dir;
    out_d.right_direction = res_r.dir;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
